@@ rtl/geohash_encoder_unit_macros.svh @@
// ---------------------------------------------------------------------------
// geohash_encoder_unit_macros.svh
// Assertion macros used by the geohash encoder RTL.
// ---------------------------------------------------------------------------
`ifndef GEOHASH_ENCODER_UNIT_MACROS_SVH
`define GEOHASH_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GHE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ghe_pkg.sv @@
// ---------------------------------------------------------------------------
// ghe_pkg
// Types and constants of the geohash encoder: bound widths, start
// intervals, sequencer states and the base32 character table.
// ---------------------------------------------------------------------------
package ghe_pkg;

	localparam int BOUND_FRACTION_BITS = 28;
	localparam int BITS_PER_CHAR       = 5;
	localparam int MAX_CHARS           = 12;

	localparam int LAT_BW = 36;
	localparam int LON_BW = 37;

	localparam logic signed [LAT_BW-1:0] LAT_HIGH_INIT =
		LAT_BW'(64'sd90 <<< BOUND_FRACTION_BITS);
	localparam logic signed [LAT_BW-1:0] LAT_LOW_INIT = -LAT_HIGH_INIT;
	localparam logic signed [LON_BW-1:0] LON_HIGH_INIT =
		LON_BW'(64'sd180 <<< BOUND_FRACTION_BITS);
	localparam logic signed [LON_BW-1:0] LON_LOW_INIT = -LON_HIGH_INIT;

	localparam logic [2:0] LAST_BIT_POS = 3'(BITS_PER_CHAR - 1);
	localparam logic [3:0] MAX_COUNT_M1 = 4'(MAX_CHARS - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// ASCII codes of "0123456789bcdefghjkmnpqrstuvwxyz"
	localparam logic [6:0] ALPHABET [32] = '{
		7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
		7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
		7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
		7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
	};

endpackage

@@ rtl/ghe_bisect.sv @@
// ---------------------------------------------------------------------------
// ghe_bisect
// Shared bisection unit: midpoint of one interval and a strict compare of
// the coordinate against it. Used for both axes in turn.
// ---------------------------------------------------------------------------
module ghe_bisect #(
	parameter int W = 38
) (
	input  logic signed [W-1:0] value,
	input  logic signed [W-1:0] lo,
	input  logic signed [W-1:0] hi,
	output logic                above,
	output logic signed [W-1:0] mid
);

	logic signed [W:0] sum;

	// Bounds sum is always even, so the halving is exact
	assign sum   = {lo[W-1], lo} + {hi[W-1], hi};
	assign mid   = $signed(sum[W:1]);
	assign above = (value > mid);

endmodule

@@ rtl/geohash_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// geohash_encoder_unit: one bisection per cycle through a shared compare unit,
// except while a finished character waits on a blocked output register.
// Requests: a new one is accepted only while idle, after the last is loaded.
// Reset: arst_n clears sequencer and output valid; the block comes up idle.
// ---------------------------------------------------------------------------
module geohash_encoder_unit #(
	parameter int COORD_FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // latitude[31:0], longitude[64:32], precision[68:65]
	// characters
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // character[6:0]
	output logic        m_axis_tlast
);

	`include "geohash_encoder_unit_macros.svh"

	localparam int SHIFT = ghe_pkg::BOUND_FRACTION_BITS - COORD_FRACTION_BITS;
	localparam int W     = 62 - COORD_FRACTION_BITS;
	localparam int LAT_BW = ghe_pkg::LAT_BW;
	localparam int LON_BW = ghe_pkg::LON_BW;

	ghe_pkg::state_t state_q;

	logic signed [31:0]       lat_q;
	logic signed [32:0]       lon_q;
	logic [3:0]               count_m1_q;
	logic signed [LAT_BW-1:0] lat_lo_q, lat_hi_q;
	logic signed [LON_BW-1:0] lon_lo_q, lon_hi_q;
	logic                     on_lon_q;
	logic [2:0]               bit_pos_q;
	logic [3:0]               sym_q;
	logic [3:0]               chars_done_q;

	logic       m_valid_q;
	logic [6:0] m_char_q;
	logic       m_last_q;

	logic             s_accept;
	logic [3:0]       prec_in;
	logic [3:0]       prec_m1;
	logic             char_end;
	logic             step;
	logic             last_char;
	logic [4:0]       symbol;
	logic signed [W-1:0] value, lo, hi, mid;
	logic             above;

	assign s_axis_tready = (state_q == ghe_pkg::ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Saturate precision into 1..MAX_CHARS, held as count minus one
	assign prec_in = s_axis_tdata[68:65];
	always_comb begin
		if (prec_in == 4'd0) begin
			prec_m1 = 4'd0;
		end else if (prec_in > 4'(ghe_pkg::MAX_CHARS)) begin
			prec_m1 = ghe_pkg::MAX_COUNT_M1;
		end else begin
			prec_m1 = prec_in - 4'd1;
		end
	end

	// Select the axis for the shared unit, scaled to bound resolution
	always_comb begin
		if (on_lon_q) begin
			value = $signed({{(W-33){lon_q[32]}}, lon_q}) <<< SHIFT;
			lo    = $signed({{(W-LON_BW){lon_lo_q[LON_BW-1]}}, lon_lo_q});
			hi    = $signed({{(W-LON_BW){lon_hi_q[LON_BW-1]}}, lon_hi_q});
		end else begin
			value = $signed({{(W-32){lat_q[31]}}, lat_q}) <<< SHIFT;
			lo    = $signed({{(W-LAT_BW){lat_lo_q[LAT_BW-1]}}, lat_lo_q});
			hi    = $signed({{(W-LAT_BW){lat_hi_q[LAT_BW-1]}}, lat_hi_q});
		end
	end

	ghe_bisect #(
		.W(W)
	) u_bisect (
		.value(value),
		.lo   (lo),
		.hi   (hi),
		.above(above),
		.mid  (mid)
	);

	// Hold on the fifth bit while the output register is occupied and not taken
	assign char_end  = (bit_pos_q == ghe_pkg::LAST_BIT_POS);
	assign step      = (state_q == ghe_pkg::ST_RUN) &&
	                   (!char_end || !m_valid_q || m_axis_tready);
	assign last_char = (chars_done_q == count_m1_q);
	assign symbol    = {sym_q, above};

	// Sequencer and bisection counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ghe_pkg::ST_IDLE;
			on_lon_q     <= 1'b1;
			bit_pos_q    <= 3'd0;
			sym_q        <= 4'd0;
			chars_done_q <= 4'd0;
		end else begin
			case (state_q)
				ghe_pkg::ST_IDLE: begin
					if (s_accept) begin
						state_q      <= ghe_pkg::ST_RUN;
						on_lon_q     <= 1'b1;
						bit_pos_q    <= 3'd0;
						sym_q        <= 4'd0;
						chars_done_q <= 4'd0;
					end
				end
				ghe_pkg::ST_RUN: begin
					if (step) begin
						on_lon_q <= !on_lon_q;
						if (char_end) begin
							bit_pos_q    <= 3'd0;
							sym_q        <= 4'd0;
							chars_done_q <= chars_done_q + 4'd1;
							if (last_char) begin
								state_q <= ghe_pkg::ST_IDLE;
							end
						end else begin
							bit_pos_q <= bit_pos_q + 3'd1;
							sym_q     <= symbol[3:0];
						end
					end
				end
				default: begin
					state_q <= ghe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Capture the request and narrow the active interval
	always_ff @(posedge clk) begin
		if (s_accept) begin
			lat_q      <= $signed(s_axis_tdata[31:0]);
			lon_q      <= $signed(s_axis_tdata[64:32]);
			count_m1_q <= prec_m1;
			lat_lo_q   <= ghe_pkg::LAT_LOW_INIT;
			lat_hi_q   <= ghe_pkg::LAT_HIGH_INIT;
			lon_lo_q   <= ghe_pkg::LON_LOW_INIT;
			lon_hi_q   <= ghe_pkg::LON_HIGH_INIT;
		end else if (step) begin
			if (on_lon_q) begin
				if (above) begin
					lon_lo_q <= mid[LON_BW-1:0];
				end else begin
					lon_hi_q <= mid[LON_BW-1:0];
				end
			end else begin
				if (above) begin
					lat_lo_q <= mid[LAT_BW-1:0];
				end else begin
					lat_hi_q <= mid[LAT_BW-1:0];
				end
			end
		end
	end

	// Output register: load a character, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && char_end) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && char_end) begin
			m_char_q <= ghe_pkg::ALPHABET[symbol];
			m_last_q <= last_char;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_char_q};
	assign m_axis_tlast  = m_last_q;

	// Checks on sequencer behavior
	`GHE_ASSERT_NEXT(a_accept_restart, clk, arst_n, s_accept, on_lon_q && (bit_pos_q == 3'd0) && (chars_done_q == 4'd0) && (state_q == ghe_pkg::ST_RUN), "request did not restart the bisection")
	`GHE_ASSERT_NEXT(a_stall_holds, clk, arst_n, (state_q == ghe_pkg::ST_RUN) && char_end && m_valid_q && !m_axis_tready, $stable(bit_pos_q) && $stable(chars_done_q) && $stable(on_lon_q), "sequencer advanced while output was blocked")
	`GHE_ASSERT_NEXT(a_last_to_idle, clk, arst_n, step && char_end && last_char, (state_q == ghe_pkg::ST_IDLE) && m_axis_tvalid && m_axis_tlast, "final character did not end the request")

endmodule
